// File: rtl/mt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt_pkg: shared definitions for the Mersenne Twister generator
// Table size, index widths, algorithm constants, operation codes and the
// status bundle passed from the sequencer core to the stream wrapper.
// ----------------------------------------------------------------------------
package mt_pkg;

  // Table geometry.
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;

  // The index must hold STATE_WORDS itself, while an address only spans the table.
  localparam int unsigned IDX_W  = $clog2(STATE_WORDS + 1);
  localparam int unsigned ADDR_W = $clog2(STATE_WORDS);
  localparam int unsigned SUM_W  = $clog2(STATE_WORDS + TWIST_OFFSET);

  localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

  // Algorithm constants.
  localparam logic [31:0] MAT_A     = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [31:0] LOW_BITS  = 32'h7FFF_FFFF;
  localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;

  // Operation codes carried on the input tuser.
  localparam logic OP_EXTRACT = 1'b0;
  localparam logic OP_SEED    = 1'b1;

  // Status from the core to the wrapper.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_status_t;

endpackage
`default_nettype wire

// File: rtl/mt19937_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_generator: 32-bit Mersenne Twister stream generator
// An extract transaction passes through the read and output states of the
// sequencer and then the output register; one that must first twist the table
// walks the whole table before that read. The next transaction is accepted only
// when the core is idle again; a seed transaction walks the table word by word.
// Reset clears the sequencer and sets the read index to STATE_WORDS; the
// table itself is undefined until a seed transaction fills it.
// ----------------------------------------------------------------------------
module mt19937_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] seed
  input  wire logic [0:0]  in_tuser,   // [0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // [31:0] value
);

  mt_pkg::core_status_t status;
  logic [31:0]          res_data;
  logic                 start;
  logic                 res_ready;
  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_data_r;

  // Input transaction starts the core when it is idle.
  assign in_tready = status.idle;
  assign start     = in_tvalid && in_tready;

  // The output register accepts a new result when empty or being drained.
  assign res_ready = !out_valid_r || out_tready;

  mt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_tuser[0]),
    .seed      (in_tdata),
    .res_ready (res_ready),
    .status    (status),
    .res_data  (res_data)
  );

  // Output register valid tracking.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output data capture.
  always_ff @(posedge clk) begin
    if (status.res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/mt_temper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt_temper: output tempering
// Applies the four shift, mask and xor steps to one table word.
// ----------------------------------------------------------------------------
module mt_temper (
  input  wire logic [31:0] word,
  output logic      [31:0] tempered
);

  logic [31:0] y1;
  logic [31:0] y2;
  logic [31:0] y3;

  // Four dependent but shallow xor stages.
  always_comb begin
    y1       = word ^ (word >> 11);
    y2       = y1 ^ ((y1 << 7) & mt_pkg::TEMPER_B);
    y3       = y2 ^ ((y2 << 15) & mt_pkg::TEMPER_C);
    tempered = y3 ^ (y3 >> 18);
  end

endmodule
`default_nettype wire

// File: rtl/mt_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mt_core: state table, sequencer and shared update unit
// Holds the state table memory and walks it word by word for seeding and
// for the twist, then reads and tempers one word per extract transaction.
// ----------------------------------------------------------------------------
module mt_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 op,
  input  wire logic [31:0]          seed,
  input  wire logic                 res_ready,
  output mt_pkg::core_status_t      status,
  output logic      [31:0]          res_data
);

  localparam int unsigned IDX_W  = mt_pkg::IDX_W;
  localparam int unsigned ADDR_W = mt_pkg::ADDR_W;
  localparam int unsigned SUM_W  = mt_pkg::SUM_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SD_MUL = 4'd1;
  localparam logic [3:0] S_SD_ADD = 4'd2;
  localparam logic [3:0] S_TW_PRE = 4'd3;
  localparam logic [3:0] S_TW_LD  = 4'd4;
  localparam logic [3:0] S_TW_RD  = 4'd5;
  localparam logic [3:0] S_TW_WR  = 4'd6;
  localparam logic [3:0] S_EX_RD  = 4'd7;
  localparam logic [3:0] S_EX_OUT = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       prev_r, prev_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [31:0]       cur_r, cur_nxt;

  // State table memory with one write and two registered read ports.
  logic [31:0]       mem [mt_pkg::STATE_WORDS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [31:0]       rd_a_r;
  logic [31:0]       rd_b_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // Twist neighbor addresses, wrapping at the end of the table.
  logic [IDX_W-1:0] nxt_idx;
  logic [SUM_W-1:0] far_sum;
  logic [SUM_W-1:0] far_wrap;

  always_comb begin
    nxt_idx  = (cnt_r == mt_pkg::LAST_IDX) ? '0 : cnt_r + 1'b1;
    far_sum  = SUM_W'(cnt_r) + SUM_W'(mt_pkg::TWIST_OFFSET);
    far_wrap = (far_sum >= SUM_W'(mt_pkg::STATE_WORDS)) ?
               far_sum - SUM_W'(mt_pkg::STATE_WORDS) : far_sum;
  end

  // Shared update unit: seeding multiply-add or twist recurrence.
  logic [31:0] mix;
  logic [31:0] seed_word;
  logic [31:0] tw_x;
  logic [31:0] tw_word;

  always_comb begin
    mix       = prev_r ^ (prev_r >> 30);
    prod_nxt  = 32'(mix * mt_pkg::INIT_MULT);
    seed_word = prod_r + 32'(cnt_r);
    tw_x      = (cur_r & mt_pkg::HIGH_BIT) | (rd_a_r & mt_pkg::LOW_BITS);
    tw_word   = rd_b_r ^ (tw_x >> 1) ^ (tw_x[0] ? mt_pkg::MAT_A : 32'd0);
  end

  // Tempering of the word read at the extract index.
  mt_temper u_temper (
    .word     (rd_a_r),
    .tempered (res_data)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[ADDR_W-1:0];
    mem_wdata = seed_word;
    addr_a    = idx_r[ADDR_W-1:0];
    addr_b    = far_wrap[ADDR_W-1:0];
    status    = '{idle: 1'b0, res_valid: 1'b0};
    case (state_r)
      S_IDLE: begin
        status.idle = 1'b1;
        if (start) begin
          if (op == mt_pkg::OP_SEED) begin
            // Word zero is the seed itself.
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = seed;
            prev_nxt  = seed;
            cnt_nxt   = IDX_W'(1);
            state_nxt = S_SD_MUL;
          end else if (idx_r == mt_pkg::FULL_IDX) begin
            cnt_nxt   = '0;
            state_nxt = S_TW_PRE;
          end else begin
            state_nxt = S_EX_RD;
          end
        end
      end
      S_SD_MUL: begin
        state_nxt = S_SD_ADD;
      end
      S_SD_ADD: begin
        mem_we   = 1'b1;
        prev_nxt = seed_word;
        if (cnt_r == mt_pkg::LAST_IDX) begin
          idx_nxt   = mt_pkg::FULL_IDX;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_SD_MUL;
        end
      end
      S_TW_PRE: begin
        // Fetch word zero as the first current word.
        addr_a    = '0;
        state_nxt = S_TW_LD;
      end
      S_TW_LD: begin
        cur_nxt   = rd_a_r;
        state_nxt = S_TW_RD;
      end
      S_TW_RD: begin
        addr_a    = nxt_idx[ADDR_W-1:0];
        state_nxt = S_TW_WR;
      end
      S_TW_WR: begin
        // The next word becomes the current word of the following step.
        mem_we    = 1'b1;
        mem_wdata = tw_word;
        cur_nxt   = rd_a_r;
        if (cnt_r == mt_pkg::LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_EX_RD;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_TW_RD;
        end
      end
      S_EX_RD: begin
        state_nxt = S_EX_OUT;
      end
      S_EX_OUT: begin
        // Address stays at the index, so the read data holds while waiting.
        status.res_valid = 1'b1;
        if (res_ready) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= mt_pkg::FULL_IDX;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    prev_r <= prev_nxt;
    prod_r <= prod_nxt;
    cur_r  <= cur_nxt;
  end

  // The read index never passes the table size.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= mt_pkg::FULL_IDX)
    else $error("read index beyond table size");

  // A pending result holds its value until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    status.res_valid && !res_ready |=> status.res_valid && $stable(res_data))
    else $error("result changed while stalled");

  // The table is not written while a result is presented.
  a_no_write_out: assert property (@(posedge clk) disable iff (!rst_n)
    status.res_valid |-> !mem_we)
    else $error("table write during result hand-off");

  // Finishing a seed walk leaves the index at the table size.
  a_seed_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SD_ADD && cnt_r == mt_pkg::LAST_IDX |=> idx_r == mt_pkg::FULL_IDX)
    else $error("seed walk did not arm the twist");

endmodule
`default_nettype wire
